// ----- rtl/prb_pkg.sv -----
// shared types, widths and constants of the probing permutation builder
`default_nettype none

package prb_pkg;

  localparam int unsigned SLOTS_DEF    = 64;
  localparam int unsigned WORD_W       = 31;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned OUT_SLOT_W   = 6;
  localparam int unsigned RANK_W       = 6;
  localparam int unsigned PERM_SIZE_RST = 64;
  // occupancy rows held in the map memory
  localparam int unsigned ROW_W        = 16;
  localparam int unsigned OFF_W        = $clog2(ROW_W);

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
  } in_word_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic [RANK_W-1:0]     rank;
    logic                  last;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] perm_size;
  } cfg_word_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] bit_idx;
  } scan_res_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_READ  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/prb_stream_if.sv -----
// valid/ready channel carrying one word of type T
`default_nettype none

interface prb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/prb_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module prb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/prb_mod_unit.sv -----
// iterative restoring remainder of the random word by the active size, one bit per cycle
`default_nettype none

module prb_mod_unit
  import prb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic [CFG_W-1:0]  size_i,
  output logic              done_o,
  output logic [CFG_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;

  // remainder stays below size, so one compare and subtract per bit
  assign trial = {rem_q, word_q[WORD_W-1]};
  assign diff  = trial - {1'b0, size_i};
  assign rem_d = (trial >= {1'b0, size_i}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    word_d = word_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      word_d = word_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q + 1'b1;
      word_d = word_q << 1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (start_i) begin
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == CNT_LAST);
  assign rem_o  = rem_d;

endmodule

`default_nettype wire

// ----- rtl/prb_row_scan.sv -----
// finds the lowest free slot at or above, or the highest free slot below, the probe in one row
`default_nettype none

module prb_row_scan
  import prb_pkg::*;
#(
  parameter int unsigned RA_W = 2
) (
  input  logic [ROW_W-1:0] bits_i,
  input  logic [RA_W-1:0]  row_i,
  input  logic [CFG_W-1:0] first_i,
  input  logic [CFG_W-1:0] size_i,
  input  logic             down_i,
  output scan_res_t        res_o
);

  localparam int unsigned P_W   = RA_W + OFF_W;
  localparam int unsigned CMP_W = (P_W > CFG_W) ? P_W : CFG_W;

  logic [ROW_W-1:0] free;

  always_comb begin
    logic [CMP_W-1:0] pos;
    for (int k = 0; k < ROW_W; k++) begin
      pos = CMP_W'({row_i, OFF_W'(k)});
      free[k] = !bits_i[k] && (pos < CMP_W'(size_i)) &&
                (down_i ? (pos < CMP_W'(first_i)) : (pos >= CMP_W'(first_i)));
    end
  end

  always_comb begin
    res_o.found   = |free;
    res_o.bit_idx = '0;
    if (down_i) begin
      // highest free bit wins
      for (int k = 0; k < ROW_W; k++) begin
        if (free[k]) begin
          res_o.bit_idx = OFF_W'(k);
        end
      end
    end else begin
      // lowest free bit wins
      for (int k = ROW_W - 1; k >= 0; k--) begin
        if (free[k]) begin
          res_o.bit_idx = OFF_W'(k);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/probing_permutation_builder.sv -----
// Builds a random permutation of the active size (perm_size, 0 read as 1, capped at SLOTS),
// one rank per input word: the word is reduced modulo the size to a probed slot, and the
// first free slot at or above it, else the nearest free slot below it, takes the next rank.
// The occupancy map lives in a ram of 16-slot rows with a valid flop per row, so a finished
// permutation or a perm_size write clears it at once with no sweep. Steps per word: accept it,
// reduce it in the bit-serial modulo unit, then read and scan one row per visit (ram read
// plus scan), upward from the probed row to the last row and then downward from the probed row,
// and hand the result to the output register. With SLOTS of 64 a word takes one row visit
// when the probed row has room and at most five, plus any wait for the output register to empty.
// A new word is taken while the previous result still waits in the output register.
`default_nettype none

module probing_permutation_builder
  import prb_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  prb_stream_if.sink   in_i,
  prb_stream_if.source out_o,
  prb_stream_if.sink   cfg_i
);

  localparam int unsigned ROWS     = (SLOTS + ROW_W - 1) / ROW_W;
  localparam int unsigned RA_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned P_W      = RA_W + OFF_W;
  localparam int unsigned CFG_MAX  = (1 << CFG_W) - 1;
  localparam int unsigned ACT_MAXI = (SLOTS > CFG_MAX) ? CFG_MAX : SLOTS;
  localparam int unsigned ACT_RSTI = (SLOTS > PERM_SIZE_RST) ? PERM_SIZE_RST : SLOTS;
  localparam logic [CFG_W-1:0] ACT_MAX = CFG_W'(ACT_MAXI);
  localparam logic [CFG_W-1:0] ACT_RST = CFG_W'(ACT_RSTI);

  state_e           state_q, state_d;
  logic [CFG_W-1:0] size_q, size_d;
  logic [CFG_W-1:0] rank_q, rank_d;
  logic [CFG_W-1:0] first_q, first_d;
  logic [RA_W-1:0]  row_q, row_d;
  logic             down_q, down_d;
  logic [ROWS-1:0]  row_vld_q, row_vld_d;
  logic             out_vld_q, out_vld_d;
  out_word_t        res_q, res_d;
  out_word_t        out_q, out_d;

  logic             div_start;
  logic             div_done;
  logic [CFG_W-1:0] div_rem;
  logic             ram_re;
  logic             ram_we;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] row_bits;
  logic [ROW_W-1:0] pick_mask;
  scan_res_t        scan;
  logic [P_W-1:0]   pick;
  logic [CFG_W-1:0] size_m1;
  logic [CFG_W-1:0] rank_inc;
  logic [RA_W-1:0]  last_row;
  logic [RA_W-1:0]  first_row;
  logic [RA_W-1:0]  div_row;
  logic [CFG_W-1:0] cfg_size;
  logic [CFG_W-1:0] cfg_act;

  assign cfg_size = cfg_i.data.perm_size;
  assign cfg_act  = (cfg_size == '0) ? CFG_W'(1) :
                    ((cfg_size > ACT_MAX) ? ACT_MAX : cfg_size);

  assign size_m1   = size_q - 1'b1;
  assign last_row  = RA_W'(size_m1 >> OFF_W);
  assign first_row = RA_W'(first_q >> OFF_W);
  assign div_row   = RA_W'(div_rem >> OFF_W);
  assign rank_inc  = rank_q + 1'b1;

  // a row never written since the last clear reads as all free
  assign row_bits  = row_vld_q[row_q] ? ram_rdata : '0;
  assign pick_mask = ROW_W'(1) << scan.bit_idx;
  assign ram_wdata = row_bits | pick_mask;
  assign pick      = {row_q, scan.bit_idx};

  prb_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .word_i  (in_i.data.random_word),
    .size_i  (size_q),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  prb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (row_q),
    .rdata_o (ram_rdata)
  );

  prb_row_scan #(
    .RA_W (RA_W)
  ) u_scan (
    .bits_i  (row_bits),
    .row_i   (row_q),
    .first_i (first_q),
    .size_i  (size_q),
    .down_i  (down_q),
    .res_o   (scan)
  );

  always_comb begin
    state_d   = state_q;
    size_d    = size_q;
    rank_d    = rank_q;
    first_d   = first_q;
    row_d     = row_q;
    down_d    = down_q;
    row_vld_d = row_vld_q;
    out_vld_d = out_vld_q;
    res_d     = res_q;
    out_d     = out_q;
    div_start = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          first_d = div_rem;
          row_d   = div_row;
          down_d  = 1'b0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (scan.found) begin
          ram_we     = 1'b1;
          res_d.slot = OUT_SLOT_W'(pick);
          res_d.rank = RANK_W'(rank_q);
          if (rank_inc >= size_q) begin
            res_d.last = 1'b1;
            rank_d     = '0;
            row_vld_d  = '0;
          end else begin
            res_d.last       = 1'b0;
            rank_d           = rank_inc;
            row_vld_d[row_q] = 1'b1;
          end
          state_d = ST_FIN;
        end else if (!down_q) begin
          if (row_q == last_row) begin
            down_d = 1'b1;
            row_d  = first_row;
          end else begin
            row_d = row_q + 1'b1;
          end
          state_d = ST_READ;
        end else if (row_q == '0) begin
          // map full: answer slot zero and leave the map alone
          res_d.slot = '0;
          res_d.rank = RANK_W'(rank_q);
          res_d.last = 1'b0;
          state_d    = ST_FIN;
        end else begin
          row_d   = row_q - 1'b1;
          state_d = ST_READ;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a size write restarts the build
    if (cfg_i.valid) begin
      size_d    = cfg_act;
      rank_d    = '0;
      row_vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      size_q    <= ACT_RST;
      rank_q    <= '0;
      down_q    <= 1'b0;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      size_q    <= size_d;
      rank_q    <= rank_d;
      down_q    <= down_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    row_q   <= row_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ----- rtl/prb_checker.sv -----
// port-level checks of the probing permutation builder, bound to the top level
`default_nettype none

module prb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [5:0] out_slot_i,
  input logic [5:0] out_rank_i,
  input logic       out_last_i,
  input logic       cfg_valid_i,
  input logic       cfg_ready_i,
  input logic [6:0] cfg_size_i
);

  logic [6:0] size_q;
  logic [5:0] exp_rank_q;
  logic       out_acc;
  logic       cfg_acc;

  assign out_acc = out_valid_i && out_ready_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= 7'd64;
      exp_rank_q <= '0;
    end else begin
      if (cfg_acc) begin
        size_q     <= cfg_size_i;
        exp_rank_q <= '0;
      end else if (out_acc) begin
        exp_rank_q <= out_last_i ? 6'd0 : exp_rank_q + 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slot_i) &&
      $stable(out_rank_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> ((size_q == 7'd0) ? (out_slot_i == 6'd0) : ({1'b0, out_slot_i} < size_q)))
    else $error("slot outside the active size");

  a_rank_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (out_rank_i == exp_rank_q))
    else $error("ranks not handed out in order");

endmodule

bind probing_permutation_builder prb_checker u_prb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_slot_i  (out_o.data.slot),
  .out_rank_i  (out_o.data.rank),
  .out_last_i  (out_o.data.last),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_size_i  (cfg_i.data.perm_size)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking testbench for the probing permutation builder
`default_nettype none

module tb;
  import prb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_COUNT  = SLOTS_DEF;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_WORDS = 1900;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  prb_stream_if #(.T(in_word_t))  in_if ();
  prb_stream_if #(.T(out_word_t)) out_if ();
  prb_stream_if #(.T(cfg_word_t)) cfg_if ();

  probing_permutation_builder u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the block: occupancy, rank counter and size register
  logic [SLOT_COUNT-1:0] occupied_slots;
  int unsigned           rank_counter;
  logic [CFG_W-1:0]      size_setting;

  out_word_t pending_placements[$];

  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned perms_done;
  int unsigned size_writes;
  int unsigned mismatches;
  bit          steady_send;
  bit          steady_recv;
  int unsigned hold_request;

  function automatic int unsigned active_slots();
    int unsigned n;
    n = size_setting;
    if (n == 0) n = 1;
    if (n > SLOT_COUNT) n = SLOT_COUNT;
    return n;
  endfunction

  function automatic void restart_build();
    occupied_slots = '0;
    rank_counter   = 0;
  endfunction

  // probe upward from the reduced slot, then downward below it
  function automatic out_word_t place_next_rank(logic [WORD_W-1:0] w);
    int unsigned n;
    int unsigned wv;
    int unsigned first;
    int unsigned pick;
    bit          found;
    out_word_t   r;
    n     = active_slots();
    wv    = w;
    first = wv % n;
    found = 1'b0;
    pick  = 0;
    for (int i = first; i < n; i++) begin
      if (!found && !occupied_slots[i]) begin
        pick  = i;
        found = 1'b1;
      end
    end
    for (int i = int'(first) - 1; i >= 0; i--) begin
      if (!found && !occupied_slots[i]) begin
        pick  = i;
        found = 1'b1;
      end
    end
    r.slot = pick[OUT_SLOT_W-1:0];
    r.rank = rank_counter[RANK_W-1:0];
    r.last = 1'b0;
    if (found) begin
      occupied_slots[pick] = 1'b1;
      rank_counter++;
      if (rank_counter >= n) begin
        r.last = 1'b1;
        restart_build();
      end
    end else begin
      r.slot = '0;
    end
    return r;
  endfunction

  initial begin
    size_setting = PERM_SIZE_RST[CFG_W-1:0];
    restart_build();
  end

  // result checking and prediction at every accepted word
  always @(posedge clk) begin : scoreboard
    out_word_t want;
    out_word_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        results_seen++;
        if (pending_placements.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: slot %0d rank %0d last %0d",
                     got.slot, got.rank, got.last);
        end else begin
          want = pending_placements.pop_front();
          if (got.slot !== want.slot || got.rank !== want.rank || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected slot %0d rank %0d last %0d, got slot %0d rank %0d last %0d",
                       want.slot, want.rank, want.last, got.slot, got.rank, got.last);
          end else if (got.last) begin
            perms_done++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        size_setting = cfg_if.data.perm_size;
        restart_build();
      end
      if (in_if.valid && in_if.ready)
        pending_placements.push_back(place_next_rank(in_if.data.random_word));
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result receiver with random gaps and an optional long hold-off
  initial begin : result_sink
    int unsigned gap;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = steady_recv ? 0 : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    int unsigned gap;
    gap = steady_send ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data.random_word <= w;
    do @(posedge clk); while (!in_if.ready);
    words_sent++;
  endtask

  // stop offering words and wait until every result is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_placements.size() != 0);
  endtask

  task automatic write_perm_size(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data.perm_size <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    size_writes++;
  endtask

  task automatic resize(input logic [CFG_W-1:0] v);
    drain_results();
    write_perm_size(v);
  endtask

  // mix of extremes, small values and near-multiples of the size
  function automatic logic [WORD_W-1:0] draw_word(int unsigned n);
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = '1;
      1: w = '0;
      2: w = WORD_W'($urandom_range(0, 127));
      3: w = WORD_W'(n * $urandom_range(1, 100000) - 1);
      default: w = WORD_W'($urandom);
    endcase
    return w;
  endfunction

  task automatic test_directed_cases();
    // reset size of 64, collisions probe up and then down
    send_word(31'h0000_0000);
    send_word(31'h0000_0000);
    send_word(31'h0000_0040);
    send_word(31'h0000_003f);
    send_word(31'h0000_007f);
    send_word(31'h7fff_ffff);
    send_word(31'h2aaa_aaaa);
    send_word(31'h5555_5555);
    // size zero behaves as one slot
    resize(7'd0);
    send_word(31'h7fff_ffff);
    send_word(31'h0000_0005);
    // oversize capped at the slot count
    resize(7'h7f);
    send_word(31'h0000_0064);
    send_word(31'h4000_0000);
    // rewriting the same size restarts the build
    resize(7'd3);
    send_word(31'h0000_0002);
    send_word(31'h0000_0002);
    resize(7'd3);
    send_word(31'h0000_0002);
    send_word(31'h0000_0005);
    send_word(31'h0000_0001);
    resize(7'd1);
    send_word(31'h0000_0009);
    resize(7'd2);
    send_word(31'h0000_0001);
    send_word(31'h0000_0001);
    drain_results();
  endtask

  task automatic test_random_permutations();
    int unsigned stop_at;
    int unsigned n;
    int unsigned count;
    logic [CFG_W-1:0] sz;
    logic [CFG_W-1:0] corner[7];
    corner  = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd65, 7'h7f};
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0)
        sz = corner[$urandom_range(0, 6)];
      else
        sz = CFG_W'($urandom_range(1, SLOT_COUNT));
      resize(sz);
      n = active_slots();
      steady_send = ($urandom_range(0, 7) == 0);
      steady_recv = steady_send;
      // whole permutations, sometimes a broken one cut short by the next write
      count = n * $urandom_range(1, 3);
      if (n > 1 && $urandom_range(0, 3) == 0)
        count += $urandom_range(1, n - 1);
      repeat (count) send_word(draw_word(n));
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
    drain_results();
  endtask

  task automatic test_output_backpressure();
    resize(7'd64);
    steady_send  = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (16) send_word(draw_word(SLOT_COUNT));
    steady_send = 1'b0;
    drain_results();
  endtask

  task automatic test_sender_pause();
    resize(7'd40);
    repeat (15) send_word(draw_word(40));
    // build continues across the pause without a size write
    drain_results();
    repeat ($urandom_range(5, 30)) @(posedge clk);
    repeat (40) send_word(draw_word(40));
    drain_results();
  endtask

  initial begin : main
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    words_sent   = 0;
    results_seen = 0;
    perms_done   = 0;
    size_writes  = 0;
    mismatches   = 0;
    steady_send  = 1'b0;
    steady_recv  = 1'b0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_permutations();
    test_output_backpressure();
    test_sender_pause();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_placements.size() != 0) begin
      mismatches += pending_placements.size();
      $display("%0d results never arrived", pending_placements.size());
    end
    $display("run: %0d words in, %0d results out, %0d permutations completed",
             words_sent, results_seen, perms_done);
    $display("run: %0d size writes incl. 0, 1, 64, 127; output hold-off and sender pause done",
             size_writes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/prb_pkg.sv
rtl/prb_stream_if.sv
rtl/prb_ram.sv
rtl/prb_mod_unit.sv
rtl/prb_row_scan.sv
rtl/probing_permutation_builder.sv
rtl/prb_checker.sv
tb/sv/tb.sv
